// ===== rtl/core/tgarle_pkg.sv =====
// Shared types and constants for the true-colour TGA run-length pixel decoder.
package tgarle_pkg;

    localparam int unsigned COLUMN_BITS_DEFAULT = 16;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PIXEL_DEPTH_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RLE_ENABLED      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_WIDTH       = 2'd2;

    localparam logic [1:0] DEPTH_RGB555 = 2'd0;
    localparam logic [1:0] DEPTH_BGR24  = 2'd1;
    localparam logic [1:0] DEPTH_BGRA32 = 2'd2;

    localparam logic [1:0] BYTE_POS_FIRST  = 2'd0;
    localparam logic [1:0] BYTE_POS_SECOND = 2'd1;
    localparam logic [1:0] BYTE_POS_THIRD  = 2'd2;
    localparam logic [1:0] BYTE_POS_FOURTH = 2'd3;

    localparam logic [7:0] PACKET_COUNT_MASK = 8'd127;

    typedef struct packed {
        logic       line_end;
        logic [7:0] repeat_count;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } result_t;

endpackage

// ===== rtl/core/tga_truecolor_rle_pixel_decoder.sv =====
// Top level of the true-colour TGA run-length pixel decoder.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] data_byte
//  m_axis    out        tdata red, green, blue, repeat_count; tlast line_end
//  cfg       in         cfg_index register number, cfg_data value
//
// One byte is taken in every cycle while s_axis_tready is high; each pixel result is registered.
// The decode state and the colour unpacking sit between the byte and the result register.
// A two-entry output stage (result register and skid register) lets input continue while
// a result waits; s_axis_tready drops only when both entries are full.
// Reset is asynchronous and active low, and the configuration port is always ready.
module tga_truecolor_rle_pixel_decoder #(
    parameter int unsigned COLUMN_BITS = tgarle_pkg::COLUMN_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] data_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] repeat_count
    output logic [31:0]                           m_axis_tdata,
    output logic                                  m_axis_tlast,  // line_end
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tgarle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tgarle_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int unsigned WIDTH_BITS = COLUMN_BITS + 1;

    logic [1:0]             depth_mode_reg;
    logic                   rle_enabled_reg;
    logic [15:0]            line_width_reg;

    logic                   awaiting_header_reg, awaiting_header_next;
    logic                   packet_is_run_reg, packet_is_run_next;
    logic [7:0]             packet_left_reg, packet_left_next;
    logic [1:0]             byte_position_reg, byte_position_next;
    logic [23:0]            pixel_bytes_reg, pixel_bytes_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;

    tgarle_pkg::result_t    out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    tgarle_pkg::result_t    skid_reg, skid_next;
    logic                   skid_valid_reg, skid_valid_next;

    logic                   in_accept;
    logic                   have_result;
    tgarle_pkg::result_t    result;

    logic [16:0]            width_cap;
    logic [WIDTH_BITS-1:0]  eff_width;
    logic [1:0]             last_index;
    logic [23:0]            assembled;
    logic [15:0]            word;
    logic [7:0]             want;
    logic [WIDTH_BITS-1:0]  room;
    logic [WIDTH_BITS-1:0]  count;
    logic [WIDTH_BITS-1:0]  column_sum;
    logic                   past_width;
    logic                   line_done;
    logic                   pop;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.repeat_count, out_reg.blue, out_reg.green, out_reg.red};
    assign m_axis_tlast  = out_reg.line_end;

    assign width_cap = 17'd1 << COLUMN_BITS;

    always_comb
    begin
        if ((line_width_reg == 16'd0) || ({1'b0, line_width_reg} > width_cap))
        begin
            eff_width = WIDTH_BITS'(width_cap);
        end
        else
        begin
            eff_width = WIDTH_BITS'(line_width_reg);
        end
    end

    always_comb
    begin
        case (depth_mode_reg)
            tgarle_pkg::DEPTH_RGB555: last_index = tgarle_pkg::BYTE_POS_SECOND;
            tgarle_pkg::DEPTH_BGR24:  last_index = tgarle_pkg::BYTE_POS_THIRD;
            default:                  last_index = tgarle_pkg::BYTE_POS_FOURTH;
        endcase
    end

    always_comb
    begin
        case (byte_position_reg)
            tgarle_pkg::BYTE_POS_FIRST:  assembled = {16'd0, s_axis_tdata};
            tgarle_pkg::BYTE_POS_SECOND: assembled = pixel_bytes_reg | {8'd0, s_axis_tdata, 8'd0};
            tgarle_pkg::BYTE_POS_THIRD:  assembled = pixel_bytes_reg | {s_axis_tdata, 16'd0};
            default:                     assembled = pixel_bytes_reg;
        endcase
    end

    assign word = assembled[15:0];

    always_comb
    begin
        if (!rle_enabled_reg || !packet_is_run_reg || (packet_left_reg == 8'd0))
        begin
            want = 8'd1;
        end
        else
        begin
            want = packet_left_reg;
        end
    end

    assign past_width = {1'b0, column_reg} >= eff_width;
    assign room       = past_width ? WIDTH_BITS'(1) : (eff_width - {1'b0, column_reg});
    assign count      = (WIDTH_BITS'(want) > room) ? room : WIDTH_BITS'(want);
    assign column_sum = {1'b0, column_reg} + count;
    assign line_done  = past_width || (column_sum >= eff_width);

    always_comb
    begin
        result.line_end     = line_done;
        result.repeat_count = count[7:0];
        if (depth_mode_reg == tgarle_pkg::DEPTH_RGB555)
        begin
            result.blue  = {word[4:0], 3'b000};
            result.green = {word[9:5], 3'b000};
            result.red   = {word[14:10], 3'b000};
        end
        else
        begin
            result.blue  = assembled[7:0];
            result.green = assembled[15:8];
            result.red   = assembled[23:16];
        end
    end

    always_comb
    begin
        awaiting_header_next = awaiting_header_reg;
        packet_is_run_next   = packet_is_run_reg;
        packet_left_next     = packet_left_reg;
        byte_position_next   = byte_position_reg;
        pixel_bytes_next     = pixel_bytes_reg;
        column_next          = column_reg;
        have_result          = 1'b0;
        if (in_accept)
        begin
            if (rle_enabled_reg && awaiting_header_reg)
            begin
                packet_left_next     = (s_axis_tdata & tgarle_pkg::PACKET_COUNT_MASK) + 8'd1;
                packet_is_run_next   = s_axis_tdata[7];
                awaiting_header_next = 1'b0;
                byte_position_next   = tgarle_pkg::BYTE_POS_FIRST;
                pixel_bytes_next     = 24'd0;
            end
            else
            begin
                pixel_bytes_next = assembled;
                if (byte_position_reg < last_index)
                begin
                    byte_position_next = byte_position_reg + 2'd1;
                end
                else
                begin
                    byte_position_next = tgarle_pkg::BYTE_POS_FIRST;
                    have_result        = 1'b1;
                    column_next        = line_done ? '0 : column_sum[COLUMN_BITS-1:0];
                    if (rle_enabled_reg)
                    begin
                        if (packet_is_run_reg || line_done || (packet_left_reg <= 8'd1))
                        begin
                            awaiting_header_next = 1'b1;
                            packet_left_next     = 8'd0;
                        end
                        else
                        begin
                            packet_left_next = packet_left_reg - 8'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = have_result;
            end
        end
        else if (have_result)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg      <= tgarle_pkg::DEPTH_BGR24;
            rle_enabled_reg     <= 1'b0;
            line_width_reg      <= 16'd1;
            awaiting_header_reg <= 1'b1;
            packet_is_run_reg   <= 1'b0;
            packet_left_reg     <= 8'd0;
            byte_position_reg   <= tgarle_pkg::BYTE_POS_FIRST;
            pixel_bytes_reg     <= 24'd0;
            column_reg          <= '0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tgarle_pkg::CFG_PIXEL_DEPTH_MODE: depth_mode_reg  <= cfg_data[1:0];
                    tgarle_pkg::CFG_RLE_ENABLED:      rle_enabled_reg <= cfg_data[0];
                    tgarle_pkg::CFG_LINE_WIDTH:       line_width_reg  <= cfg_data;
                    default:                          ;
                endcase
            end
            awaiting_header_reg <= awaiting_header_next;
            packet_is_run_reg   <= packet_is_run_next;
            packet_left_reg     <= packet_left_next;
            byte_position_reg   <= byte_position_next;
            pixel_bytes_reg     <= pixel_bytes_next;
            column_reg          <= column_next;
            out_valid_reg       <= out_valid_next;
            skid_valid_reg      <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while the result register is empty");

    a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] != 8'd0))
        else $error("result transaction with a zero repeat count");

    a_packet_left_live: assert property (@(posedge clk) disable iff (!rst_n)
        !awaiting_header_reg |-> (packet_left_reg != 8'd0))
        else $error("open packet with no pixels left");

    a_header_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && rle_enabled_reg && awaiting_header_reg)
            |=> (!awaiting_header_reg && (byte_position_reg == tgarle_pkg::BYTE_POS_FIRST)))
        else $error("header transaction did not open a packet");

    a_no_result_from_header: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && rle_enabled_reg && awaiting_header_reg) |-> !have_result)
        else $error("header transaction produced a pixel result");
`endif

endmodule

// ===== tb/tb_tga_truecolor_rle_pixel_decoder.sv =====
// Self-checking testbench for the true-colour TGA run-length pixel decoder.
module tb_tga_truecolor_rle_pixel_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] DEPTH_MODE_THREE = 2'd3;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned RANDOM_BYTES = 1550;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [tgarle_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [tgarle_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    tga_truecolor_rle_pixel_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder copy: configuration and stream state.
    logic [1:0]  depth_mode = tgarle_pkg::DEPTH_BGR24;
    logic        rle_on = 1'b0;
    logic [15:0] width_reg = 16'd1;
    logic        want_header = 1'b1;
    logic        run_packet = 1'b0;
    logic [7:0]  packet_pixels = 8'd0;
    logic [1:0]  byte_pos = tgarle_pkg::BYTE_POS_FIRST;
    logic [23:0] pixel_acc = 24'd0;
    logic [15:0] column_pos = 16'd0;

    tgarle_pkg::result_t expected_pixels[$];
    tgarle_pkg::result_t exp_px;
    tgarle_pkg::result_t got_px;
    int unsigned fail_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned long_hold_req = 0;
    bit          quiet = 1'b0;

    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic decode_byte(input logic [7:0] data);
        int unsigned w;
        int unsigned room;
        int unsigned n;
        int unsigned last;
        logic [15:0] word;
        logic        ended;
        tgarle_pkg::result_t px;
        if (rle_on && want_header)
        begin
            packet_pixels = {1'b0, data[6:0]} + 8'd1;
            run_packet = data[7];
            want_header = 1'b0;
            byte_pos = tgarle_pkg::BYTE_POS_FIRST;
            pixel_acc = 24'd0;
            return;
        end
        if (byte_pos == tgarle_pkg::BYTE_POS_FIRST)
            pixel_acc = 24'd0;
        if (byte_pos != tgarle_pkg::BYTE_POS_FOURTH)
            pixel_acc = pixel_acc | ({16'd0, data} << (8 * byte_pos));
        if (depth_mode == tgarle_pkg::DEPTH_RGB555)
            last = 1;
        else if (depth_mode == tgarle_pkg::DEPTH_BGR24)
            last = 2;
        else
            last = 3;
        if (byte_pos < last)
        begin
            byte_pos = byte_pos + 2'd1;
            return;
        end
        byte_pos = tgarle_pkg::BYTE_POS_FIRST;
        if (depth_mode == tgarle_pkg::DEPTH_RGB555)
        begin
            word = pixel_acc[15:0];
            px.blue = {word[4:0], 3'b000};
            px.green = {word[9:5], 3'b000};
            px.red = {word[14:10], 3'b000};
        end
        else
        begin
            px.blue = pixel_acc[7:0];
            px.green = pixel_acc[15:8];
            px.red = pixel_acc[23:16];
        end
        n = (rle_on && run_packet) ? packet_pixels : 1;
        if (n < 1)
            n = 1;
        w = (width_reg == 16'd0) ? 65536 : width_reg;
        room = (column_pos < w) ? (w - column_pos) : 1;
        if (n > room)
            n = room;
        ended = (column_pos >= w) || (column_pos + n >= w);
        column_pos = ended ? 16'd0 : 16'(column_pos + n);
        px.repeat_count = 8'(n);
        px.line_end = ended;
        if (rle_on)
        begin
            if (run_packet || ended || packet_pixels <= 8'd1)
            begin
                want_header = 1'b1;
                packet_pixels = 8'd0;
            end
            else
                packet_pixels = packet_pixels - 8'd1;
        end
        expected_pixels.push_back(px);
    endtask

    task automatic send_byte(input logic [7:0] data);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        decode_byte(data);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [tgarle_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [tgarle_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            tgarle_pkg::CFG_PIXEL_DEPTH_MODE: depth_mode = value[1:0];
            tgarle_pkg::CFG_RLE_ENABLED:      rle_on = value[0];
            tgarle_pkg::CFG_LINE_WIDTH:       width_reg = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] depth, input logic rle, input logic [15:0] w);
        wait_drained();
        write_register(tgarle_pkg::CFG_PIXEL_DEPTH_MODE, tgarle_pkg::CFG_DATA_BITS'(depth));
        write_register(tgarle_pkg::CFG_RLE_ENABLED, tgarle_pkg::CFG_DATA_BITS'(rle));
        write_register(tgarle_pkg::CFG_LINE_WIDTH, w);
    endtask

    task automatic send_bytes(input logic [7:0] data[]);
        foreach (data[i])
            send_byte(data[i]);
    endtask

    task automatic send_packet();
        logic [6:0] count;
        count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 7));
        if (want_header)
            send_byte({1'($urandom_range(0, 1)), count});
        while (!want_header)
            send_byte(8'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_bytes('{8'hFF, 8'h80, 8'h01});
    endtask

    task automatic test_rgb555_extremes();
        set_mode(tgarle_pkg::DEPTH_RGB555, 1'b0, 16'd3);
        send_bytes('{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    endtask

    task automatic test_alpha_depths();
        set_mode(tgarle_pkg::DEPTH_BGRA32, 1'b0, 16'd4);
        send_bytes('{8'h11, 8'h22, 8'h33, 8'h44});
        wait_drained();
        write_register(tgarle_pkg::CFG_PIXEL_DEPTH_MODE,
                       tgarle_pkg::CFG_DATA_BITS'(DEPTH_MODE_THREE));
        send_bytes('{8'hAA, 8'hBB, 8'hCC, 8'hDD});
    endtask

    task automatic test_rle_packets();
        set_mode(tgarle_pkg::DEPTH_RGB555, 1'b1, 16'd5);
        send_bytes('{8'h89, 8'h5A, 8'hA5});
        wait_drained();
        write_register(tgarle_pkg::CFG_LINE_WIDTH, 16'd3);
        send_bytes('{8'h04, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06});
        send_bytes('{8'h00, 8'hE0, 8'h03, 8'h80, 8'h1F, 8'h7C});
        wait_drained();
        write_register(tgarle_pkg::CFG_LINE_WIDTH, 16'd0);
        send_bytes('{8'hFF, 8'h34, 8'h12});
    endtask

    task automatic test_width_lowered_midline();
        set_mode(tgarle_pkg::DEPTH_RGB555, 1'b0, 16'd9);
        send_bytes('{8'h21, 8'h43});
    endtask

    task automatic test_depth_change_midpixel();
        set_mode(tgarle_pkg::DEPTH_BGRA32, 1'b0, 16'd6);
        send_bytes('{8'h9C, 8'h3E, 8'h71});
        wait_drained();
        write_register(tgarle_pkg::CFG_PIXEL_DEPTH_MODE,
                       tgarle_pkg::CFG_DATA_BITS'(tgarle_pkg::DEPTH_RGB555));
        send_byte(8'hC8);
    endtask

    task automatic test_backpressure();
        set_mode(tgarle_pkg::DEPTH_RGB555, 1'b0, 16'd7);
        quiet = 1'b1;
        long_hold_req = 300;
        repeat (60) send_byte(8'($urandom));
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_stream();
        int unsigned start;
        int unsigned budget;
        logic [1:0]  depth;
        logic [15:0] w;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            depth = ($urandom_range(0, 9) == 0) ? DEPTH_MODE_THREE
                                                : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0:       w = 16'd0;
                1:       w = 16'hFFFF;
                2:       w = 16'd1;
                3, 4:    w = 16'($urandom_range(129, 400));
                default: w = 16'($urandom_range(2, 16));
            endcase
            set_mode(depth, ($urandom_range(0, 3) != 0), w);
            quiet = ($urandom_range(0, 4) == 0);
            budget = bytes_sent + $urandom_range(40, 140);
            while (bytes_sent < budget)
            begin
                if (!rle_on)
                    send_byte(8'($urandom));
                else if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                else
                    send_packet();
            end
            quiet = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_px = {m_axis_tlast, m_axis_tdata};
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got_px);
                fail_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                check_field("red", exp_px.red, got_px.red);
                check_field("green", exp_px.green, got_px.green);
                check_field("blue", exp_px.blue, got_px.blue);
                check_field("repeat_count", exp_px.repeat_count, got_px.repeat_count);
                check_field("line_end", 8'(exp_px.line_end), 8'(got_px.line_end));
            end
        end
    end

    initial
    begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req != 0)
            begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL tga_truecolor_rle_pixel_decoder");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_rgb555_extremes();
        test_alpha_depths();
        test_rle_packets();
        test_width_lowered_midline();
        test_depth_change_midpixel();
        test_backpressure();
        test_random_stream();
        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS tga_truecolor_rle_pixel_decoder");
        else
            $display("FAIL tga_truecolor_rle_pixel_decoder");
        $finish;
    end

endmodule
